// ----- rtl/dtx_pkg.sv -----
package dtx_pkg;

   localparam int MAG_W      = 32;
   localparam int NUM_DIGITS = 10;
   localparam int POS_W      = 4;
   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 8;
   localparam int WEIGHT_W   = 34;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = 1;
   localparam int QCOUNT_W   = 2;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
   localparam logic [POS_W-1:0]  TOP_POS     = 4'(NUM_DIGITS - 1);

   // One classified request waiting between the front and the back end.
   typedef struct packed {
      logic              negative;
      logic [MAG_W-1:0]  magnitude;
   } entry_type;

   // Queue status seen by the front and back ends.
   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SIGN,
      BACK_DIGITS
   } back_state_type;

   // Weight of one decimal position: 10 raised to pos.
   function automatic logic [WEIGHT_W-1:0] pow10(input logic [POS_W-1:0] pos);
      logic [WEIGHT_W-1:0] value;
      case (pos)
         4'd0:    value = 34'd1;
         4'd1:    value = 34'd10;
         4'd2:    value = 34'd100;
         4'd3:    value = 34'd1000;
         4'd4:    value = 34'd10000;
         4'd5:    value = 34'd100000;
         4'd6:    value = 34'd1000000;
         4'd7:    value = 34'd10000000;
         4'd8:    value = 34'd100000000;
         4'd9:    value = 34'd1000000000;
         default: value = 34'd0;
      endcase
      return value;
   endfunction

endpackage

// ----- rtl/dtx_front.sv -----
module dtx_front (
   input  logic                         req_valid,
   input  logic [dtx_pkg::MAG_W-1:0]    req_value,
   output logic                         req_stall,
   input  dtx_pkg::queue_status_type    queue_status,
   output logic                         push,
   output dtx_pkg::entry_type           push_entry
);

   // Split the request into its sign and an unsigned magnitude. The negation
   // is done in 32 unsigned bits, so the most negative value maps to 2^31.
   always_comb begin
      push_entry.negative  = req_value[dtx_pkg::MAG_W-1];
      push_entry.magnitude = req_value[dtx_pkg::MAG_W-1] ? (~req_value + 32'd1) : req_value;
      req_stall            = queue_status.full;
      push                 = req_valid && !queue_status.full;
   end

endmodule

// ----- rtl/dtx_queue.sv -----
module dtx_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dtx_pkg::entry_type         push_entry,
   input  logic                       pop,
   output dtx_pkg::entry_type         head_entry,
   output dtx_pkg::queue_status_type  status
);

   dtx_pkg::entry_type                 slots_ff [dtx_pkg::QUEUE_DEPTH];
   logic [dtx_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [dtx_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [dtx_pkg::QCOUNT_W-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      status.not_empty = (count_ff != '0);
      status.full      = (count_ff == dtx_pkg::QCOUNT_W'(dtx_pkg::QUEUE_DEPTH));
      head_entry       = slots_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/dtx_back.sv -----
module dtx_back (
   input  logic                            clock,
   input  logic                            reset,
   input  dtx_pkg::queue_status_type       queue_status,
   input  dtx_pkg::entry_type              head_entry,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [dtx_pkg::CHAR_W-1:0]      rsp_character,
   output logic                            rsp_last
);

   dtx_pkg::back_state_type            state_ff, state_in;
   logic [dtx_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic [dtx_pkg::MAG_W-1:0]          rem_ff, rem_in;
   logic                               started_ff, started_in;
   logic                               valid_ff, valid_in;
   logic [dtx_pkg::CHAR_W-1:0]         char_ff, char_in;
   logic                               last_ff, last_in;

   logic                               advance;
   logic [dtx_pkg::DIGIT_W-1:0]        digit;
   logic [dtx_pkg::WEIGHT_W-1:0]       weight;
   logic [dtx_pkg::WEIGHT_W-1:0]       take;
   logic [dtx_pkg::WEIGHT_W-1:0]       rem_wide;

   // Digit of the current position: the largest k with k * 10^pos <= rem.
   always_comb begin
      weight   = dtx_pkg::pow10(pos_ff);
      rem_wide = {2'b00, rem_ff};
      digit    = '0;
      take     = '0;
      for (int k = 1; k <= 9; k++) begin
         if (rem_wide >= weight * dtx_pkg::WEIGHT_W'(k)) begin
            digit = dtx_pkg::DIGIT_W'(k);
            take  = weight * dtx_pkg::WEIGHT_W'(k);
         end
      end
   end

   always_comb begin
      advance    = !valid_ff || !rsp_stall;
      state_in   = state_ff;
      pos_in     = pos_ff;
      rem_in     = rem_ff;
      started_in = started_ff;
      valid_in   = valid_ff && rsp_stall;
      char_in    = char_ff;
      last_in    = last_ff;
      pop        = 1'b0;
      case (state_ff)
         dtx_pkg::BACK_IDLE: begin
            if (queue_status.not_empty) begin
               pop        = 1'b1;
               rem_in     = head_entry.magnitude;
               pos_in     = dtx_pkg::TOP_POS;
               started_in = 1'b0;
               state_in   = head_entry.negative ? dtx_pkg::BACK_SIGN : dtx_pkg::BACK_DIGITS;
            end
         end
         dtx_pkg::BACK_SIGN: begin
            if (advance) begin
               valid_in = 1'b1;
               char_in  = dtx_pkg::ASCII_MINUS;
               last_in  = 1'b0;
               state_in = dtx_pkg::BACK_DIGITS;
            end
         end
         dtx_pkg::BACK_DIGITS: begin
            if (advance) begin
               // Leading zeros are skipped; the units position always prints.
               if (started_ff || digit != '0 || pos_ff == '0) begin
                  valid_in   = 1'b1;
                  char_in    = dtx_pkg::ASCII_ZERO + {4'b0000, digit};
                  last_in    = (pos_ff == '0);
                  started_in = 1'b1;
               end
               rem_in = rem_ff - take[dtx_pkg::MAG_W-1:0];
               if (pos_ff == '0) begin
                  state_in = dtx_pkg::BACK_IDLE;
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = dtx_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= dtx_pkg::BACK_IDLE;
         started_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      rem_ff  <= rem_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

// ----- rtl/integer_to_decimal_text_unit.sv -----
// Channel   Direction  Ports                               Moves
// req       in         req_valid, req_stall, req_value      one signed 32-bit integer
// rsp       out        rsp_valid, rsp_stall, rsp_character, one ASCII character,
//                      rsp_last                             last marks the end
//
// In the back end each request takes a load from the queue, a sign step for a
// negative value, and one step per decimal position from 10^9 down to 10^0,
// done by the single digit extraction unit that handles one position per
// cycle while the output is not stalled.
// Reset is synchronous and active high; it empties the queue and the output.
// A stall on rsp holds the back end; the two-entry queue keeps accepting
// requests until it is full, and only then is req_stall raised.
module integer_to_decimal_text_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [dtx_pkg::MAG_W-1:0]    req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [dtx_pkg::CHAR_W-1:0]   rsp_character,
   output logic                         rsp_last
);

   // The front end classifies each request into a sign and a magnitude.
   dtx_pkg::queue_status_type  queue_status;
   dtx_pkg::entry_type         push_entry;
   dtx_pkg::entry_type         head_entry;
   logic                       push;
   logic                       pop;

   dtx_front u_front (
      .req_valid    (req_valid),
      .req_value    (req_value),
      .req_stall    (req_stall),
      .queue_status (queue_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   // The queue decouples acceptance from character emission.
   dtx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   // The back end walks the decimal positions, most significant first, and
   // drives the registered output.
   dtx_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_status  (queue_status),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- bench/testbench.sv -----
module testbench;

   // One character of decimal text, as the block should present it.
   typedef struct {
      logic [dtx_pkg::CHAR_W-1:0] character;
      logic                       last;
   } glyph_type;

   // The ledger works out the text of every accepted request. It then checks
   // the characters that come back against that text, in order.
   class decimal_text_ledger;
      glyph_type awaited[$];
      int        errors;

      // Spell one signed 32-bit value as ASCII, sign first and then the
      // digits with the most significant first. The magnitude is formed as an
      // unsigned 32-bit quantity, so the most negative value needs no special
      // handling here.
      function void note_request(logic [dtx_pkg::MAG_W-1:0] value);
         logic [dtx_pkg::MAG_W-1:0]   magnitude;
         logic [dtx_pkg::DIGIT_W-1:0] digits[$];
         glyph_type                   glyph;
         magnitude = value[dtx_pkg::MAG_W-1] ? (~value + 1'b1) : value;
         do begin
            digits.push_front(dtx_pkg::DIGIT_W'(magnitude % 10));
            magnitude = magnitude / 10;
         end while (magnitude != 0);
         if (value[dtx_pkg::MAG_W-1]) begin
            glyph.character = dtx_pkg::ASCII_MINUS;
            glyph.last = 1'b0;
            awaited.push_back(glyph);
         end
         foreach (digits[i]) begin
            glyph.character = dtx_pkg::ASCII_ZERO + dtx_pkg::CHAR_W'(digits[i]);
            glyph.last = (i == digits.size() - 1);
            awaited.push_back(glyph);
         end
      endfunction

      function void check_glyph(logic [dtx_pkg::CHAR_W-1:0] character, logic last);
         glyph_type wanted;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected character %0d last %0b", $time, character, last);
            errors++;
         end else begin
            wanted = awaited.pop_front();
            if (character !== wanted.character) begin
               $display("%0t: character expected %0d actual %0d", $time,
                        wanted.character, character);
               errors++;
            end
            if (last !== wanted.last) begin
               $display("%0t: last expected %0b actual %0b", $time, wanted.last, last);
               errors++;
            end
         end
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [dtx_pkg::MAG_W-1:0]  req_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [dtx_pkg::CHAR_W-1:0] rsp_character;
   logic                       rsp_last;

   // While steady is set, neither the sender nor the receiver idles. This
   // gives one long stretch in which the block runs at its full rate.
   bit steady = 1'b0;

   decimal_text_ledger ledger = new();

   integer_to_decimal_text_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // The bench changes inputs only at rising edges, and the block's outputs
   // change only there too. A value seen at the falling edge is therefore the
   // value that the next rising edge acts on. All handshakes are judged at the
   // falling edge, so the order of events within an edge plays no part.

   // Offer one request and hold it until the block takes it. An idle gap of
   // random length may come first. Valid is only lowered during such a gap,
   // so it is never lowered and raised again in the same step.
   task automatic send_value(input logic [dtx_pkg::MAG_W-1:0] value);
      bit accepted;
      while (!steady && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do begin
         @(negedge clock);
         accepted = !req_stall;
         // The request is noted before the edge that takes it, which is
         // always ahead of its first character.
         if (accepted)
            ledger.note_request(value);
         @(posedge clock);
      end while (!accepted);
   endtask

   // Stop sending and wait for every awaited character to come back.
   task automatic drain_text();
      req_valid <= 1'b0;
      while (ledger.outstanding() != 0)
         @(posedge clock);
   endtask

   // Draw a random value. Half of the values are shaped by their digit count, so
   // that short and long numbers of both signs are common. The rest are raw
   // 32-bit words, values near zero, or values around a power of ten.
   function automatic logic [dtx_pkg::MAG_W-1:0] pick_value();
      int     kind;
      int     count;
      bit     negative;
      longint lower;
      longint upper;
      longint magnitude;
      kind = $urandom_range(0, 9);
      negative = $urandom_range(0, 1);
      count = $urandom_range(1, dtx_pkg::NUM_DIGITS);
      lower = 1;
      repeat (count - 1) lower = lower * 10;
      upper = lower * 10 - 1;
      if (count == dtx_pkg::NUM_DIGITS)
         upper = negative ? 64'd2147483648 : 64'd2147483647;
      if (count == 1)
         lower = 0;
      case (kind)
         0, 1, 2:
            return $urandom;
         8:
            magnitude = $urandom_range(0, 20);
         9:
            magnitude = lower + $urandom_range(0, 2) - 1;
         default:
            magnitude = lower + longint'($urandom) % (upper - lower + 1);
      endcase
      return dtx_pkg::MAG_W'(negative ? -magnitude : magnitude);
   endfunction

   // The receiver stalls at random, except in the steady stretch.
   initial begin
      forever begin
         @(posedge clock);
         rsp_stall <= !steady && ($urandom_range(99) < 22);
      end
   end

   // A character moves on the rising edge after a falling edge at which
   // valid is high and stall is low.
   always @(negedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         ledger.check_glyph(rsp_character, rsp_last);
   end

   // Stimulus. The directed requests cover zero, single digits, several digit
   // counts, some powers of ten, the largest value and the most negative value.
   // After that come random requests. There is a steady stretch in the middle
   // and two points at which the sender waits for the block to drain.
   initial begin
      logic [dtx_pkg::MAG_W-1:0] directed[$];
      directed = '{32'd0, 32'd1, -32'sd1, 32'd7, -32'sd9, 32'd10, -32'sd10,
                   32'd99, 32'd100, -32'sd999, 32'd12345, -32'sd67890,
                   32'd100000, 32'd999999999, 32'd1000000000, -32'sd1000000000,
                   32'd1234567890, -32'sd987654321, 32'h7FFFFFFF, 32'h80000001,
                   32'h80000000, 32'd4000000000, 32'd2000000000};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i])
         send_value(directed[i]);
      drain_text();
      for (int n = 0; n < 500; n++) begin
         steady = (n >= 200 && n < 320);
         if (n == 400)
            drain_text();
         send_value(pick_value());
      end
      req_valid <= 1'b0;
      while (ledger.outstanding() != 0)
         @(posedge clock);
      // Any character that the block still sends now would be one too many.
      repeat (40) @(posedge clock);
      if (ledger.outstanding() != 0)
         $display("%0t: %0d characters never arrived", $time, ledger.outstanding());
      if (ledger.errors == 0 && ledger.outstanding() == 0) begin
         $display("integer_to_decimal_text_unit test passed");
      end else begin
         $display("integer_to_decimal_text_unit test failed");
      end
      $finish;
   end

   // A slow but correct run finishes long before this time limit.
   initial begin
      #400000;
      $display("integer_to_decimal_text_unit test failed");
      $finish;
   end

endmodule
